// File: rtl/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg: shared widths and types for the triangle tangent block
// Fixed-point widths of the delta, product and division datapath, plus the
// result bundle that the iterative divider hands back to the sequencer.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int POS_W     = 32;              // corner position, Q16.16
    localparam int UV_W      = 24;              // texture coordinate, Q4.20
    localparam int UV_FRAC   = 20;              // fraction bits of a UV value
    localparam int OUT_W     = 32;              // tangent component, Q16.16

    localparam int EDGE_W    = POS_W + 1;       // position difference
    localparam int DUV_W     = UV_W + 1;        // UV difference
    localparam int PROD_W    = DUV_W + EDGE_W;  // one multiplier product
    localparam int NUM_W     = PROD_W + 1;      // numerator (product difference)
    localparam int DET_W     = 2 * DUV_W + 1;   // UV determinant
    localparam int Q_W       = OUT_W + 1;       // quotient bits kept by divider
    localparam int DIV_SHIFT = Q_W - UV_FRAC;   // numerator bits below first step
    localparam int REM_W     = DET_W + 1;       // partial remainder
    localparam int CNT_W     = $clog2(Q_W);     // divider step counter

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic           done;   // one-cycle pulse, quotient valid
        logic           ovf;    // quotient is 2^Q_W or more
        logic [Q_W-1:0] quot;   // unsigned quotient magnitude
    } div_res_t;

endpackage

// File: rtl/triangle_tangent_from_uv.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv: per-triangle tangent from position and UV deltas
// Groups incoming corners by three, then forms
//   T = (dv2 * edge1 - dv1 * edge2) / (du1 * dv2 - du2 * dv1)
// with one shared multiplier and one bit-serial divider under a sequencer.
//
//   channel | signals                                  | dir | handshake
//   --------+------------------------------------------+-----+----------------
//   corner  | pos_x/y/z, tex_u/v, mesh_end             | in  | in_valid/ready
//   tangent | tangent_x/y/z, degenerate, clipped       | out | out_valid/ready
//
// First and second corners of a triangle are taken without a stall.
// A third corner holds in_ready low while the sequencer forms the
// determinant, then for each component the numerator and a quotient from
// the bit-serial divider, and finally hands the result off. A zero
// determinant skips the components and goes straight to the hand-off.
// Asynchronous active-low reset clears the corner count and the sequencer.
// A result that waits in the output register does not block first and
// second corners; the next triangle holds in its last step until it drains.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [tt_pkg::POS_W-1:0] pos_x,
    input  logic signed [tt_pkg::POS_W-1:0] pos_y,
    input  logic signed [tt_pkg::POS_W-1:0] pos_z,
    input  logic signed [tt_pkg::UV_W-1:0]  tex_u,
    input  logic signed [tt_pkg::UV_W-1:0]  tex_v,
    input  logic                            mesh_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [tt_pkg::OUT_W-1:0] tangent_x,
    output logic signed [tt_pkg::OUT_W-1:0] tangent_y,
    output logic signed [tt_pkg::OUT_W-1:0] tangent_z,
    output logic                            degenerate,
    output logic                            clipped
);
    import tt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,     // take corners
        S_MUL_A,    // first product of a pair
        S_MUL_B,    // second product, latch the first
        S_SUB,      // difference of the pair
        S_DCHK,     // test determinant, take its magnitude
        S_NABS,     // numerator magnitude and result sign
        S_DSTART,   // launch the divider
        S_DIV,      // wait for the quotient, saturate
        S_DONE      // hand the result to the output register
    } state_t;

    // control
    state_t     state_reg, state_next;
    logic [1:0] cc_reg, cc_next;
    logic       det_phase_reg, det_phase_next;
    logic [1:0] comp_reg, comp_next;
    logic       out_valid_reg, out_valid_next;

    // held corners and deltas
    logic signed [POS_W-1:0]  held_pos_reg [0:1][0:2];
    logic signed [UV_W-1:0]   held_u_reg   [0:1];
    logic signed [UV_W-1:0]   held_v_reg   [0:1];
    logic signed [POS_W-1:0]  pos_in       [0:2];
    logic signed [EDGE_W-1:0] e1_reg       [0:2];
    logic signed [EDGE_W-1:0] e2_reg       [0:2];
    logic signed [DUV_W-1:0]  du1_reg, dv1_reg, du2_reg, dv2_reg;

    // shared multiplier and accumulation
    logic signed [DUV_W-1:0]  mul_a;
    logic signed [EDGE_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic signed [NUM_W-1:0]  diff;
    logic                     mul_second;

    // determinant, numerator and division
    logic signed [DET_W-1:0] det_reg;
    logic [DET_W-1:0]        det_abs, det_mag_reg;
    logic                    det_neg_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0]        num_abs, dvd_reg;
    logic                    neg_reg;
    logic                    div_start;
    div_res_t                div_res;
    logic [OUT_W-1:0]        sat_val;
    logic                    sat_clip;

    // result
    logic [OUT_W-1:0] tan_reg [0:2];
    logic             degen_reg, clip_reg;
    logic [OUT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic             out_degen_reg, out_clip_reg;

    logic in_acc;
    logic out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    // ------------------------------------------------------------------
    // Operand select: the determinant pairs UV deltas, each component
    // pairs a V delta with an edge.
    // ------------------------------------------------------------------
    assign mul_second = (state_reg == S_MUL_B);

    always_comb
    begin
        if (det_phase_reg)
        begin
            mul_a = mul_second ? du2_reg : du1_reg;
            mul_b = mul_second ? {{(EDGE_W-DUV_W){dv1_reg[DUV_W-1]}}, dv1_reg}
                               : {{(EDGE_W-DUV_W){dv2_reg[DUV_W-1]}}, dv2_reg};
        end
        else
        begin
            mul_a = mul_second ? dv1_reg : dv2_reg;
            mul_b = mul_second ? e2_reg[comp_reg] : e1_reg[comp_reg];
        end
    end

    assign mul_p = mul_a * mul_b;
    assign diff  = {acc_reg[PROD_W-1], acc_reg} - {prod_reg[PROD_W-1], prod_reg};

    assign det_abs = det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
    assign num_abs = num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;

    // ------------------------------------------------------------------
    // Divider: magnitudes in, quotient magnitude out
    // ------------------------------------------------------------------
    assign div_start = (state_reg == S_DSTART);

    tt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (det_mag_reg),
        .res      (div_res)
    );

    // Apply the sign and clamp to the Q16.16 range.
    always_comb
    begin
        if (neg_reg)
        begin
            sat_clip = div_res.ovf || (div_res.quot > {1'b0, SAT_NEG});
            sat_val  = sat_clip ? SAT_NEG : (~div_res.quot[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            sat_clip = div_res.ovf || (div_res.quot > {1'b0, SAT_POS});
            sat_val  = sat_clip ? SAT_POS : div_res.quot[OUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cc_next        = cc_reg;
        det_phase_next = det_phase_reg;
        comp_next      = comp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!cc_reg[1])
                    begin
                        // drop a partial triangle at the end of a mesh
                        cc_next = mesh_end ? 2'd0 : cc_reg + 2'd1;
                    end
                    else
                    begin
                        cc_next        = 2'd0;
                        det_phase_next = 1'b1;
                        state_next     = S_MUL_A;
                    end
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = S_SUB;
            end
            S_SUB:
            begin
                state_next = det_phase_reg ? S_DCHK : S_NABS;
            end
            S_DCHK:
            begin
                if (det_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    det_phase_next = 1'b0;
                    comp_next      = 2'd0;
                    state_next     = S_MUL_A;
                end
            end
            S_NABS:
            begin
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_MUL_A;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cc_reg        <= 2'd0;
            det_phase_reg <= 1'b0;
            comp_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cc_reg        <= cc_next;
            det_phase_reg <= det_phase_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!cc_reg[1])
            begin
                // hold the first or second corner
                for (int c = 0; c < 3; c++)
                begin
                    held_pos_reg[cc_reg[0]][c] <= pos_in[c];
                end
                held_u_reg[cc_reg[0]] <= tex_u;
                held_v_reg[cc_reg[0]] <= tex_v;
            end
            else
            begin
                // third corner: form all deltas against corner zero
                for (int c = 0; c < 3; c++)
                begin
                    e1_reg[c] <= {held_pos_reg[1][c][POS_W-1], held_pos_reg[1][c]}
                               - {held_pos_reg[0][c][POS_W-1], held_pos_reg[0][c]};
                    e2_reg[c] <= {pos_in[c][POS_W-1], pos_in[c]}
                               - {held_pos_reg[0][c][POS_W-1], held_pos_reg[0][c]};
                end
                du1_reg <= {held_u_reg[1][UV_W-1], held_u_reg[1]}
                         - {held_u_reg[0][UV_W-1], held_u_reg[0]};
                dv1_reg <= {held_v_reg[1][UV_W-1], held_v_reg[1]}
                         - {held_v_reg[0][UV_W-1], held_v_reg[0]};
                du2_reg <= {tex_u[UV_W-1], tex_u}
                         - {held_u_reg[0][UV_W-1], held_u_reg[0]};
                dv2_reg <= {tex_v[UV_W-1], tex_v}
                         - {held_v_reg[0][UV_W-1], held_v_reg[0]};
            end
        end

        case (state_reg)
            S_MUL_A:
            begin
                prod_reg <= mul_p;
            end
            S_MUL_B:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            S_SUB:
            begin
                det_reg <= diff[DET_W-1:0];
                num_reg <= diff;
            end
            S_DCHK:
            begin
                det_mag_reg <= det_abs;
                det_neg_reg <= det_reg[DET_W-1];
                clip_reg    <= 1'b0;
                degen_reg   <= (det_reg == '0);
                if (det_reg == '0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        tan_reg[c] <= '0;
                    end
                end
            end
            S_NABS:
            begin
                dvd_reg <= num_abs;
                neg_reg <= num_reg[NUM_W-1] ^ det_neg_reg;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    tan_reg[comp_reg] <= sat_val;
                    clip_reg          <= clip_reg | sat_clip;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_x_reg     <= tan_reg[0];
                    out_y_reg     <= tan_reg[1];
                    out_z_reg     <= tan_reg[2];
                    out_degen_reg <= degen_reg;
                    out_clip_reg  <= clip_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign tangent_x  = out_x_reg;
    assign tangent_y  = out_y_reg;
    assign tangent_z  = out_z_reg;
    assign degenerate = out_degen_reg;
    assign clipped    = out_clip_reg;

`ifndef SYNTHESIS
    // a degenerate triangle carries a zero tangent and no clip
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (tangent_x == '0) && (tangent_y == '0)
                                    && (tangent_z == '0) && !clipped)
        else $error("degenerate result with nonzero tangent or clip");

    // the divider only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider result outside the divide step");

    // an overflowing quotient must mark the triangle clipped
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done && div_res.ovf |=> clip_reg)
        else $error("quotient overflow without clip");

    // input stalls only after a third corner
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> ($past(cc_reg) == 2'd2))
        else $error("busy without a complete triangle");
`endif

endmodule

// File: rtl/tt_div.sv
// ----------------------------------------------------------------------------
// tt_div: iterative restoring divider, one quotient bit per cycle
// Computes floor(dividend * 2^UV_FRAC / divisor) on magnitudes. A first check
// flags quotients that do not fit in Q_W bits; otherwise Q_W steps follow.
// ----------------------------------------------------------------------------
module tt_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [tt_pkg::NUM_W-1:0] dividend,
    input  logic [tt_pkg::DET_W-1:0] divisor,
    output tt_pkg::div_res_t         res
);
    import tt_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   low_reg, low_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [DET_W-1:0] dsr_reg, dsr_next;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] dsr_ext;
    logic             fits;

    assign dsr_ext = {1'b0, dsr_reg};
    assign trial   = {rem_reg[REM_W-2:0], low_reg[Q_W-1]};
    assign fits    = (trial >= dsr_ext);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        dsr_next   = dsr_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next   = REM_W'(dividend >> DIV_SHIFT);
                    low_next   = {dividend[DIV_SHIFT-1:0], {UV_FRAC{1'b0}}};
                    dsr_next   = divisor;
                    quot_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                cnt_next = '0;
                // the top bits alone already reach the divisor: too large
                if (rem_reg >= dsr_ext)
                begin
                    ovf_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next  = fits ? (trial - dsr_ext) : trial;
                quot_next = {quot_reg[Q_W-2:0], fits};
                low_next  = low_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

// File: test/triangle_tangent_from_uv_tb.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_tb: self-checking bench for the triangle tangent
// Streams triangle corners into the block and predicts every tangent
// transaction in exact integer arithmetic. Compares each result field by
// field against the oldest prediction. Randomizes the gaps on the corner
// side and the stalls on the tangent side.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv_tb;

    import tt_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int IDLE_LIMIT  = 4000;     // cycles with no transaction on either side
    localparam int DRAIN_WAIT  = 200;      // longer than the worst third-corner latency
    localparam int ITEM_TARGET = 1100;
    localparam int MAX_REPORTS = 10;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << 16;
    localparam logic [UV_W-1:0]  UV_MAX  = {1'b0, {(UV_W-1){1'b1}}};
    localparam logic [UV_W-1:0]  UV_MIN  = {1'b1, {(UV_W-1){1'b0}}};
    localparam logic [UV_W-1:0]  UV_ONE  = UV_W'(1) << UV_FRAC;
    localparam int               SPAN    = 1 << 20;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [UV_W-1:0]  u;
        logic [UV_W-1:0]  v;
        logic             last;
    } corner_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic             degen;
        logic             clip;
    } tangent_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [POS_W-1:0] pos_x = '0;
    logic [POS_W-1:0] pos_y = '0;
    logic [POS_W-1:0] pos_z = '0;
    logic [UV_W-1:0]  tex_u = '0;
    logic [UV_W-1:0]  tex_v = '0;
    logic             mesh_end = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] tangent_x;
    logic [OUT_W-1:0] tangent_y;
    logic [OUT_W-1:0] tangent_z;
    logic             degenerate;
    logic             clipped;

    initial begin
        forever begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    triangle_tangent_from_uv dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .mesh_end   (mesh_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tangent_x  (tangent_x),
        .tangent_y  (tangent_y),
        .tangent_z  (tangent_z),
        .degenerate (degenerate),
        .clipped    (clipped)
    );

    // ------------------------------------------------------------------------
    // Tangent predictor: its own copy of the corner grouping and held corners
    // ------------------------------------------------------------------------
    int     corner_cnt;
    longint held_pos [2][3];
    longint held_uv  [2][2];

    // (num * 2^UV_FRAC) / det truncated toward zero, saturated to Q16.16.
    function automatic logic [OUT_W-1:0] fixed_quotient(input longint num,
                                                        input longint det,
                                                        inout bit clip);
        logic [127:0] nmag;
        logic [127:0] dmag;
        logic [127:0] quo;
        logic [127:0] limit;
        bit           neg;
        neg   = (num < 0) != (det < 0);
        nmag  = (num < 0) ? 128'(-num) : 128'(num);
        dmag  = (det < 0) ? 128'(-det) : 128'(det);
        quo   = (nmag << UV_FRAC) / dmag;
        limit = neg ? 128'(SAT_NEG) : 128'(SAT_POS);
        if (quo > limit) begin
            quo  = limit;
            clip = 1'b1;
        end
        fixed_quotient = neg ? OUT_W'(-quo) : OUT_W'(quo);
    endfunction

    // Advance the grouping by one corner; return 1 when a tangent comes out.
    function automatic bit predict_corner(input corner_t c, output tangent_t t);
        longint           cur [3];
        longint           du1, dv1, du2, dv2, det, e1, e2, num;
        logic [OUT_W-1:0] comp [3];
        bit               clip;
        cur[0] = longint'($signed(c.px));
        cur[1] = longint'($signed(c.py));
        cur[2] = longint'($signed(c.pz));
        t = '0;
        predict_corner = 1'b0;
        if (corner_cnt < 2) begin
            for (int k = 0; k < 3; k++) begin
                held_pos[corner_cnt][k] = cur[k];
            end
            held_uv[corner_cnt][0] = longint'($signed(c.u));
            held_uv[corner_cnt][1] = longint'($signed(c.v));
            corner_cnt = c.last ? 0 : corner_cnt + 1;
        end
        else begin
            corner_cnt = 0;
            predict_corner = 1'b1;
            du1 = held_uv[1][0] - held_uv[0][0];
            dv1 = held_uv[1][1] - held_uv[0][1];
            du2 = longint'($signed(c.u)) - held_uv[0][0];
            dv2 = longint'($signed(c.v)) - held_uv[0][1];
            det = du1 * dv2 - du2 * dv1;
            if (det == 0) begin
                t.degen = 1'b1;
            end
            else begin
                clip = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    e1      = held_pos[1][k] - held_pos[0][k];
                    e2      = cur[k] - held_pos[0][k];
                    num     = dv2 * e1 - dv1 * e2;
                    comp[k] = fixed_quotient(num, det, clip);
                end
                t.x    = comp[0];
                t.y    = comp[1];
                t.z    = comp[2];
                t.clip = clip;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus store and scoreboard state
    // ------------------------------------------------------------------------
    corner_t  corner_queue [$];
    tangent_t tangent_expected [$];
    int       corners_queued;
    int       corners_taken;
    int       error_cnt;
    int       idle_cycles;
    logic     in_fire = 1'b0;
    logic     out_fire = 1'b0;

    int       in_gap;
    int       out_stall;
    bit       in_burst;
    bit       out_burst;

    task automatic add_corner(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z, input logic [UV_W-1:0] u,
                              input logic [UV_W-1:0] v, input bit last);
        corner_t c;
        c.px = x;
        c.py = y;
        c.pz = z;
        c.u = u;
        c.v = v;
        c.last = last;
        corner_queue.insert(corner_queue.size(), c);
        corners_queued++;
    endtask

    function automatic logic [POS_W-1:0] rand_pos(input bit wide);
        rand_pos = wide ? POS_W'($urandom) : POS_W'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
    endfunction

    function automatic logic [UV_W-1:0] rand_uv(input bit wide);
        rand_uv = wide ? UV_W'($urandom) : UV_W'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
    endfunction

    // Mostly random waits, with stretches in which there is no wait at all.
    function automatic int draw_wait(input bit burst);
        draw_wait = burst ? 0 : int'($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------------
    // Corner driver: present at the falling edge, hold until the transaction
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : corner_driver
        corner_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire) begin
            // hold the payload until the block takes it
        end
        else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap--;
        end
        else if (corner_queue.size() > 0) begin
            c = corner_queue.pop_front();
            pos_x    <= c.px;
            pos_y    <= c.py;
            pos_z    <= c.pz;
            tex_u    <= c.u;
            tex_v    <= c.v;
            mesh_end <= c.last;
            in_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) begin
                in_burst = !in_burst;
            end
            in_gap = draw_wait(in_burst);
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Tangent sink: drop ready for a drawn number of cycles after each result
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 39) == 0) begin
                out_burst = !out_burst;
            end
            out_stall = draw_wait(out_burst);
        end
        if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each corner transaction, check each tangent
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        corner_t  seen;
        tangent_t want;
        tangent_t got;
        in_fire  <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                seen.px   = pos_x;
                seen.py   = pos_y;
                seen.pz   = pos_z;
                seen.u    = tex_u;
                seen.v    = tex_v;
                seen.last = mesh_end;
                corners_taken++;
                if (predict_corner(seen, want)) begin
                    tangent_expected.insert(tangent_expected.size(), want);
                end
            end
            if (out_valid && out_ready) begin
                got.x     = tangent_x;
                got.y     = tangent_y;
                got.z     = tangent_z;
                got.degen = degenerate;
                got.clip  = clipped;
                if (tangent_expected.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("unexpected tangent x=%h y=%h z=%h degenerate=%b clipped=%b",
                                 got.x, got.y, got.z, got.degen, got.clip);
                    end
                end
                else begin
                    want = tangent_expected.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.degen !== want.degen || got.clip !== want.clip) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $display("tangent mismatch: expected x=%h y=%h z=%h d=%b c=%b",
                                     want.x, want.y, want.z, want.degen, want.clip);
                            $display("                  actual   x=%h y=%h z=%h d=%b c=%b",
                                     got.x, got.y, got.z, got.degen, got.clip);
                        end
                    end
                end
            end
            // watchdog: count cycles in which neither side moves a transaction
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corners, random meshes, drain, verdict
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int  kind;
        bit  wide_p;
        bit  wide_uv;
        bit  timed_out;
        logic [UV_W-1:0] u0, v0, du, dv;

        corner_cnt = 0;
        timed_out  = 1'b0;

        // Directed: mesh end on the first corner right after reset
        add_corner(POS_ONE, POS_ONE, POS_ONE, UV_ONE, UV_ONE, 1'b1);
        // trailing partial triangle: mesh end on the second corner
        add_corner(POS_MAX, POS_MIN, '0, UV_MAX, UV_MIN, 1'b0);
        add_corner(POS_MIN, POS_MAX, '0, UV_MIN, UV_MAX, 1'b1);
        // unit triangle: tangent lies along +x with length one
        add_corner('0, '0, '0, '0, '0, 1'b0);
        add_corner(POS_ONE, '0, '0, UV_ONE, '0, 1'b0);
        add_corner('0, POS_ONE, '0, '0, UV_ONE, 1'b0);
        // zero determinant: all three UVs equal
        add_corner(POS_MAX, POS_MIN, POS_ONE, UV_MAX, UV_MIN, 1'b0);
        add_corner(POS_MIN, POS_MAX, '0, UV_MAX, UV_MIN, 1'b0);
        add_corner(POS_ONE, '0, POS_MAX, UV_MAX, UV_MIN, 1'b0);
        // one-LSB determinant with full-range edges: saturate both ways
        add_corner(POS_MIN, POS_MAX, POS_MIN, '0, '0, 1'b0);
        add_corner(POS_MAX, POS_MIN, POS_MIN, UV_W'(1), '0, 1'b0);
        add_corner(POS_MIN, POS_MAX, POS_MAX, '0, UV_W'(1), 1'b0);
        // extreme UV corners, mesh end on the third corner
        add_corner(POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MIN, 1'b0);
        add_corner(POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MIN, 1'b0);
        add_corner(POS_MIN, POS_MAX, POS_MIN, UV_MIN, UV_MAX, 1'b1);
        // same extremes mirrored, with the determinant still positive
        add_corner(POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MAX, 1'b0);
        add_corner(POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MAX, 1'b0);
        add_corner('0, '0, '0, UV_MAX, UV_MIN, 1'b0);
        // mesh end on a second corner, then a fresh triangle right after
        add_corner(POS_ONE, POS_ONE, POS_ONE, '0, '0, 1'b0);
        add_corner('0, '0, '0, '0, '0, 1'b1);
        add_corner('0, '0, '0, '0, '0, 1'b0);
        add_corner('0, '0, POS_ONE, '0, UV_ONE, 1'b0);
        add_corner(POS_ONE, '0, '0, UV_ONE, '0, 1'b0);

        // Random meshes: mostly whole triangles, some flat ones, some cut short
        while (corners_queued < ITEM_TARGET) begin
            kind    = $urandom_range(0, 99);
            wide_p  = ($urandom_range(0, 9) < 3);
            wide_uv = ($urandom_range(0, 9) < 3);
            if (kind < 8) begin
                // partial triangle closed by mesh end on corner one or two
                if ($urandom_range(0, 1)) begin
                    add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                               rand_uv(wide_uv), rand_uv(wide_uv), 1'b0);
                end
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           rand_uv(wide_uv), rand_uv(wide_uv), 1'b1);
            end
            else if (kind < 18) begin
                // collinear UVs give an exactly zero determinant
                u0 = rand_uv(1'b0);
                v0 = rand_uv(1'b0);
                du = UV_W'(int'($urandom_range(0, 2 * (SPAN >> 2))) - (SPAN >> 2));
                dv = ($urandom_range(0, 3) == 0) ? '0 :
                     UV_W'(int'($urandom_range(0, 2 * (SPAN >> 2))) - (SPAN >> 2));
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           u0, v0, 1'b0);
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           u0 + du, v0 + dv, 1'b0);
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           u0 + (du << 1), v0 + (dv << 1), $urandom_range(0, 9) == 0);
            end
            else begin
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           rand_uv(wide_uv), rand_uv(wide_uv), 1'b0);
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           rand_uv(wide_uv), rand_uv(wide_uv), 1'b0);
                add_corner(rand_pos(wide_p), rand_pos(wide_p), rand_pos(wide_p),
                           rand_uv(wide_uv), rand_uv(wide_uv), $urandom_range(0, 9) == 0);
            end
        end

        // hold reset, then release it away from the sampling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // advance until every corner is taken and every tangent has arrived
        while ((corners_taken < corners_queued || tangent_expected.size() > 0) &&
               idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
        end

        if (idle_cycles >= IDLE_LIMIT) begin
            timed_out = 1'b1;
        end
        else begin
            // let any stray result show up before the verdict
            repeat (DRAIN_WAIT) @(posedge clk);
        end

        if (tangent_expected.size() > 0) begin
            error_cnt++;
        end

        if (timed_out || error_cnt != 0) begin
            $display("FAIL");
        end
        else begin
            $display("PASS");
        end
        $finish;
    end

endmodule

// File: triangle_tangent_from_uv.f
rtl/tt_pkg.sv
rtl/tt_div.sv
rtl/triangle_tangent_from_uv.sv
test/triangle_tangent_from_uv_tb.sv
